// ----- rtl/ultrasonic_tank_level_defines.svh -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_TANK_LEVEL_DEFINES_SVH
`define ULTRASONIC_TANK_LEVEL_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define UTL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ultrasonic_tank_level check failed");

// Invariant checked on every clock edge outside reset.
`define UTL_ASSERT_NEVER(lbl, bad) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(bad)) \
    else $error("ultrasonic_tank_level check failed");

`endif

// ----- rtl/utl_pkg.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level package
// Shared constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package utl_pkg;

  localparam logic [7:0] REG_FULL_DEPTH = 8'd0;
  localparam logic [7:0] REG_BLIND_ZONE = 8'd1;
  localparam logic [7:0] REG_SPACING    = 8'd2;
  localparam logic [7:0] REG_CAPACITY   = 8'd3;
  localparam logic [7:0] REG_NO_ECHO    = 8'd4;

  localparam int NUM_W  = 48;  // divider numerator width
  localparam int DEN_W  = 25;  // divider denominator width
  localparam int QUO_W  = 33;  // divider quotient width, one stage per bit
  localparam int SQRT_W = 32;  // root bits, one stage per bit
  localparam int HP_W   = 39;  // echo * speed plus rounding bias

  // Half path = (echo * speed + HALF_BIAS) * HALF_RECIP >> 55, which equals
  // the rounded quotient of echo * speed * 256 by 20000000 over the full
  // range of the product.
  localparam logic [HP_W-1:0] HALF_BIAS  = 39'd39062;
  localparam logic [HP_W-1:0] HALF_RECIP = 39'd461168601843;

  typedef struct packed {
    logic [9:0]  full_depth;
    logic [7:0]  blind_zone;
    logic [7:0]  spacing;
    logic [19:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic            ok;
    logic [HP_W-1:0] num;
  } item_t;

  // Packed from the top bit down, so reading_ok lands in bit 0.
  typedef struct packed {
    logic        below_empty;
    logic        over_full;
    logic [19:0] stored_litres;
    logic [13:0] fill_hundredth_pct;
    logic [13:0] depth_sixteenth_cm;
    logic [14:0] range_sixteenth_cm;
    logic        reading_ok;
  } result_t;

endpackage

// ----- rtl/utl_front.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level front end
// Accepts readings, flags unusable ones and forms the half-path dividend.
// ----------------------------------------------------------------------------
module utl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         echo,
  input  logic [11:0]         temp,
  input  logic [15:0]         no_echo,
  input  logic [9:0]          full_depth,
  output logic                push,
  output utl_pkg::item_t      item,
  input  logic                fifo_full
);

  logic               v1, v2, ok1, ok2;
  logic [15:0]        echo1;
  logic [22:0]        speed1;
  logic [38:0]        prod2;
  logic               en;
  logic signed [23:0] speed_s;

  assign en       = !(v2 && fifo_full);
  assign in_ready = en;
  assign push     = v2 && en;
  assign speed_s  = 24'sd5300800 + $signed({{12{temp[11]}}, temp}) * 24'sd606;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1    <= (echo != no_echo) && (full_depth != 10'd0);
      echo1  <= echo;
      speed1 <= speed_s[22:0];
      ok2    <= ok1;
      prod2  <= 39'(echo1) * 39'(speed1);
    end
  end

  assign item.ok  = ok2;
  assign item.num = prod2 + utl_pkg::HALF_BIAS;

endmodule

// ----- rtl/utl_fifo.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level queue
// Four-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module utl_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  utl_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output utl_pkg::item_t rdata,
  output logic           empty
);

  utl_pkg::item_t mem [0:3];
  logic [2:0]     wr_ptr, rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[1:0] == rd_ptr[1:0]) && (wr_ptr[2] != rd_ptr[2]);
  assign rdata = mem[rd_ptr[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 3'd0;
      rd_ptr <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 3'd1;
      if (pop) rd_ptr <= rd_ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr[1:0]] <= wdata;
  end

endmodule

// ----- rtl/utl_div.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module utl_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [utl_pkg::NUM_W-1:0]   num,
  input  logic [utl_pkg::DEN_W-1:0]   den,
  output logic [utl_pkg::QUO_W-1:0]   quo
);

  localparam int EXT_W = utl_pkg::NUM_W + utl_pkg::QUO_W;

  logic [utl_pkg::NUM_W-1:0] rem [0:utl_pkg::QUO_W-1];
  logic [utl_pkg::QUO_W-1:0] qb  [0:utl_pkg::QUO_W-1];

  for (genvar i = 0; i < utl_pkg::QUO_W; i++) begin : g_stage
    logic [utl_pkg::NUM_W-1:0] rin;
    logic [utl_pkg::QUO_W-1:0] qin;
    logic [EXT_W-1:0]          trial;
    logic                      ge;
    if (i == 0) begin : g_first
      assign rin = num;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[i-1];
      assign qin = qb[i-1];
    end
    assign trial = EXT_W'(den) << (utl_pkg::QUO_W - 1 - i);
    assign ge    = EXT_W'(rin) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? rin - trial[utl_pkg::NUM_W-1:0] : rin;
        qb[i]  <= {qin[utl_pkg::QUO_W-2:0], ge};
      end
    end
  end

  assign quo = qb[utl_pkg::QUO_W-1];

endmodule

// ----- rtl/utl_sqrt.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level square root
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module utl_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [63:0]                val,
  output logic [utl_pkg::SQRT_W-1:0] root
);

  logic [63:0] v   [0:utl_pkg::SQRT_W-1];
  logic [63:0] res [0:utl_pkg::SQRT_W-1];

  for (genvar i = 0; i < utl_pkg::SQRT_W; i++) begin : g_stage
    logic [63:0] vin, rin, t, bitv;
    if (i == 0) begin : g_first
      assign vin = val;
      assign rin = '0;
    end else begin : g_next
      assign vin = v[i-1];
      assign rin = res[i-1];
    end
    assign bitv = 64'd1 << (62 - 2 * i);
    assign t    = rin + bitv;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vin >= t) begin
          v[i]   <= vin - t;
          res[i] <= (rin >> 1) + bitv;
        end else begin
          v[i]   <= vin;
          res[i] <= rin >> 1;
        end
      end
    end
  end

  assign root = res[utl_pkg::SQRT_W-1][utl_pkg::SQRT_W-1:0];

endmodule

// ----- rtl/utl_back.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level back end
// Half path, triangle correction, depth clamp, fill and volume pipeline.
// ----------------------------------------------------------------------------
module utl_back (
  input  logic             clk,
  input  logic             rst,
  input  utl_pkg::cfg_t    cfg,
  input  utl_pkg::item_t   rdata,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output utl_pkg::result_t result
);

  // Stage layout: half-path reciprocal multiply, five squaring stages,
  // square root, two range stages, clamp, numerators, output divider.
  localparam int HF_STAGES = 3;
  localparam int SQ_STAGES = 5;
  localparam int RG_STAGES = 2;
  localparam int L = HF_STAGES + SQ_STAGES + utl_pkg::SQRT_W + RG_STAGES + 2
                     + utl_pkg::QUO_W;

  logic         en;
  logic         vld [0:L-1];
  logic         okp [0:L-1];

  logic [18:0]  rm_h, rk_h;
  logic [19:0]  rm_l, rk_l;
  logic [37:0]  rp_hh, rp_hh2;
  logic [38:0]  rp_hl, rp_lh;
  logic [39:0]  rp_ll;
  logic [40:0]  rmid;
  logic [58:0]  rsum;

  logic [utl_pkg::QUO_W-1:0] half, fill_q, lit_q;
  logic [15:0]  hh;
  logic [16:0]  hl;
  logic [15:0]  hh1;
  logic [33:0]  p0;
  logic [32:0]  p1;
  logic [51:0]  s01;
  logic [31:0]  p2;
  logic [63:0]  sq, a25, dval, bval;
  logic [31:0]  root;
  logic [32:0]  t;
  logic         sat;
  logic [17:0]  y;
  logic [33:0]  yq;
  logic [14:0]  rng_r2, rng_h1;
  logic [13:0]  f16, hc_h1;
  logic signed [16:0] hs;
  logic         over_h1, under_h1;
  logic [28:0]  nf;
  logic [35:0]  nl;
  logic [30:0]  side_d2;
  logic [30:0]  side [0:utl_pkg::QUO_W-1];

  assign en  = !(out_valid && !out_ready);
  assign pop = en && !empty;

  assign f16  = {cfg.full_depth, 4'b0};
  assign bval = 64'(16'(cfg.spacing) * 16'(cfg.spacing)) << 20;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= !empty;
      for (int k = 1; k < L; k++) vld[k] <= vld[k-1];
      out_valid <= vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okp[0] <= rdata.ok;
      for (int k = 1; k < L; k++) okp[k] <= okp[k-1];
    end
  end

  // Half path by reciprocal multiplication, split into four partial
  // products, a middle sum and a final sum with the shift by 55.
  assign rm_h = rdata.num[38:20];
  assign rm_l = rdata.num[19:0];
  assign rk_h = utl_pkg::HALF_RECIP[38:20];
  assign rk_l = utl_pkg::HALF_RECIP[19:0];
  assign rsum = (59'(rp_hh2) << 20) + 59'(rmid);

  always_ff @(posedge clk) begin
    if (en) begin
      rp_hh  <= 38'(rm_h) * 38'(rk_h);
      rp_hl  <= 39'(rm_h) * 39'(rk_l);
      rp_lh  <= 39'(rm_l) * 39'(rk_h);
      rp_ll  <= 40'(rm_l) * 40'(rk_l);
      rp_hh2 <= rp_hh;
      rmid   <= 41'(rp_hl) + 41'(rp_lh) + 41'(rp_ll[39:20]);
      half   <= 33'(rsum[58:35]);
    end
  end

  // The square is kept modulo 2^64.
  assign hh = half[32:17];
  assign hl = half[16:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= 34'(hl) * 34'(hl);
      p1   <= 33'(hh) * 33'(hl);
      hh1  <= hh;
      s01  <= 52'(p0) + (52'(p1) << 18);
      p2   <= 32'(hh1) * 32'(hh1);
      sq   <= 64'(s01) + (64'(p2) << 34);
      a25  <= (sq << 4) + (sq << 3) + sq;
      dval <= (a25 > bval) ? a25 - bval : 64'd0;
    end
  end

  utl_sqrt u_sqrt (.clk (clk), .en (en), .val (dval), .root (root));

  // Range = (root + 640) / 1280, as a shift by 8 and a reciprocal divide by 5.
  assign t  = 33'(root) + 33'd640;
  assign yq = 34'(y) * 34'd52429;
  assign hs = $signed({3'b0, f16}) + $signed({5'b0, cfg.blind_zone, 4'b0})
              - $signed({2'b0, rng_r2});

  always_ff @(posedge clk) begin
    if (en) begin
      sat      <= t >= 33'd41943040;
      y        <= t[25:8];
      rng_r2   <= sat ? 15'h7fff : yq[32:18];
      rng_h1   <= rng_r2;
      over_h1  <= hs > $signed({3'b0, f16});
      under_h1 <= hs < 17'sd0;
      if (hs > $signed({3'b0, f16})) hc_h1 <= f16;
      else if (hs < 17'sd0) hc_h1 <= 14'd0;
      else hc_h1 <= hs[13:0];
      nf       <= 29'(29'(hc_h1) * 29'd20000) + 29'(f16);
      nl       <= 36'(36'({cfg.capacity, 1'b0}) * 36'(hc_h1)) + 36'(f16);
      side_d2  <= {rng_h1, hc_h1, over_h1, under_h1};
    end
  end

  utl_div u_fill (
    .clk (clk), .en (en), .num (48'(nf)), .den (25'({f16, 1'b0})), .quo (fill_q)
  );
  utl_div u_lit (
    .clk (clk), .en (en), .num (48'(nl)), .den (25'({f16, 1'b0})), .quo (lit_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_d2;
      for (int k = 1; k < utl_pkg::QUO_W; k++) side[k] <= side[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (okp[L-1]) begin
        result.reading_ok         <= 1'b1;
        result.range_sixteenth_cm <= side[utl_pkg::QUO_W-1][30:16];
        result.depth_sixteenth_cm <= side[utl_pkg::QUO_W-1][15:2];
        result.over_full          <= side[utl_pkg::QUO_W-1][1];
        result.below_empty        <= side[utl_pkg::QUO_W-1][0];
        result.fill_hundredth_pct <= fill_q[13:0];
        result.stored_litres      <= lit_q[19:0];
      end else begin
        result <= '0;
      end
    end
  end

endmodule

// ----- rtl/ultrasonic_tank_level.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic tank level converter
// Echo time and air temperature in, range, depth, fill and volume out.
// ----------------------------------------------------------------------------
// The slave stream takes one reading per transaction: the echo time in
// microseconds and the headspace air temperature in 1/16 degree. The master
// stream returns exactly one result per reading, in order. The configuration
// channel writes the tank geometry, capacity and no-echo code; cfg_ready is
// always high, and writes are meant to happen while the block is empty.
// Throughput is one reading per cycle while the receiver is ready. An
// accepted reading passes through two front-end stages, the queue, and a
// 78-stage back end set mainly by the two parallel 33-stage restoring
// dividers for fill and volume and the 32-stage square root; the half path
// takes a three-stage reciprocal multiply. When the receiver stalls, the
// back end freezes and the four-entry queue fills; the front end keeps
// accepting until the queue is full, then drops s_axis_tready. Reset empties
// the pipeline and queue and restores the registers to zero, with a no-echo
// code of 65535.
// ----------------------------------------------------------------------------
`include "ultrasonic_tank_level_defines.svh"

module ultrasonic_tank_level (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] echo_time_us, [27:16] air_temp_sixteenths, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] reading_ok, [15:1] range_sixteenth_cm, [29:16] depth_sixteenth_cm,
  // [43:30] fill_hundredth_pct, [63:44] stored_litres, [64] over_full,
  // [65] below_empty, [71:66] zero
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  utl_pkg::cfg_t    cfg;
  logic [15:0]      no_echo;
  logic             push, fifo_full, pop, empty;
  utl_pkg::item_t   wr_item, rd_item;
  utl_pkg::result_t result;

  assign cfg_ready = 1'b1;

  // Register file; writes to indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg     <= '0;
      no_echo <= 16'hffff;
    end else if (cfg_valid) begin
      case (cfg_index)
        utl_pkg::REG_FULL_DEPTH: cfg.full_depth <= cfg_data[9:0];
        utl_pkg::REG_BLIND_ZONE: cfg.blind_zone <= cfg_data[7:0];
        utl_pkg::REG_SPACING:    cfg.spacing    <= cfg_data[7:0];
        utl_pkg::REG_CAPACITY:   cfg.capacity   <= cfg_data;
        utl_pkg::REG_NO_ECHO:    no_echo        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front end: classify the reading and form echo * speed plus the
  // rounding bias of the half-path quotient.
  utl_front u_front (
    .clk (clk), .rst (rst),
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
    .echo (s_axis_tdata[15:0]), .temp (s_axis_tdata[27:16]),
    .no_echo (no_echo), .full_depth (cfg.full_depth),
    .push (push), .item (wr_item), .fifo_full (fifo_full)
  );

  utl_fifo u_fifo (
    .clk (clk), .rst (rst), .push (push), .wdata (wr_item), .full (fifo_full),
    .pop (pop), .rdata (rd_item), .empty (empty)
  );

  // Back end: everything after the dividend, ending in the output register.
  utl_back u_back (
    .clk (clk), .rst (rst), .cfg (cfg), .rdata (rd_item), .empty (empty),
    .pop (pop), .out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
    .result (result)
  );

  assign m_axis_tdata = {6'b0, result};

  // A reading without a level carries all-zero fields.
  `UTL_ASSERT_IMPL(a_no_level_zero, m_axis_tvalid && !result.reading_ok, m_axis_tdata == 72'd0)
  // The two clamp flags never fire together.
  `UTL_ASSERT_NEVER(a_flags_exclusive, m_axis_tvalid && result.over_full && result.below_empty)
  // Fill never exceeds one hundred percent.
  `UTL_ASSERT_IMPL(a_fill_bound, m_axis_tvalid, result.fill_hundredth_pct <= 14'd10000)
  // The queue never takes a push while full.
  `UTL_ASSERT_NEVER(a_no_overflow, push && fifo_full)

endmodule
